// ----- design/abg_pkg.sv -----
// Shared types and constants of the anchor box generator.
package abg_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int COORD_W = 20;
  localparam int SIZE_W = 26;
  localparam int NUM_W = 52;
  localparam int DEN_W = 23;
  localparam int ROOT_W = NUM_W / 2;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CELL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_MIN   = 2'd0,
    KIND_SQRT  = 2'd1,
    KIND_RATIO = 2'd2,
    KIND_FIXED = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_MAP_WIDTH    = 3'd2,
    CFG_MAP_HEIGHT   = 3'd3,
    CFG_ENTRY_COUNT  = 3'd4,
    CFG_CLIP_ENABLE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  entry_index;
    kind_e       kind;
    logic [15:0] size_a;
    logic [15:0] size_b;
    logic [15:0] ratio;
    logic [9:0]  cell_col;
    logic [9:0]  cell_row;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
  } shape_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [9:0]  map_width;
    logic [9:0]  map_height;
    logic [4:0]  entry_count;
    logic        clip_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] xmin;
    logic signed [COORD_W-1:0] ymin;
    logic signed [COORD_W-1:0] xmax;
    logic signed [COORD_W-1:0] ymax;
    logic                      fits_image;
    logic                      has_fit_flag;
    logic [3:0]                shape_index;
    logic                      last_box;
  } box_t;

endpackage

// ----- design/anchor_box_generator.sv -----
// A load writes the table as it leaves the queue; a cell holds the back end through each counted
// table entry in turn, min and fixed entries quickest, aspect ratio slowest. Each box edge waits
// on the shared 52-step divider and each root on the root unit. One item is worked at a time; a
// full output register holds emit. The two-entry input queue lets the sender run two transfers
// ahead. Reset (rst_ni low, async) restores the register defaults and empties the queue; the
// shape table must be loaded first.
module anchor_box_generator import abg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_index, entry_kind, size_a, size_b, ratio, cell_col, cell_row, zero fill
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // box_xmin, box_ymin, box_xmax, box_ymax, shape_index, zero fill
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // fits_image, has_fit_flag
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, pop;
  box_t  box;

  // Configuration is always taken; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 12'd300;
      cfg_q.image_height <= 12'd300;
      cfg_q.map_width    <= 10'd38;
      cfg_q.map_height   <= 10'd38;
      cfg_q.entry_count  <= 5'd0;
      cfg_q.clip_enable  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        CFG_MAP_WIDTH:    cfg_q.map_width    <= cfg_data_i[9:0];
        CFG_MAP_HEIGHT:   cfg_q.map_height   <= cfg_data_i[9:0];
        CFG_ENTRY_COUNT:  cfg_q.entry_count  <= cfg_data_i[4:0];
        CFG_CLIP_ENABLE:  cfg_q.clip_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify transfers into the queue.
  abg_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .pop_i(pop), .item_valid_o(item_valid), .item_o(item)
  );

  // Back: table writes and box generation, with the output register.
  abg_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_valid_i(item_valid), .item_i(item), .pop_o(pop),
    .box_valid_o(m_axis_tvalid), .box_ready_i(m_axis_tready), .box_o(box)
  );

  assign m_axis_tdata = {4'd0, box.shape_index, box.ymax, box.xmax, box.ymin, box.xmin};
  assign m_axis_tuser = {box.has_fit_flag, box.fits_image};
  assign m_axis_tlast = box.last_box;

endmodule

// ----- design/abg_front.sv -----
// Front end: unpack and classify input transfers into a two-entry queue.
module abg_front import abg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 pop_i,
  output logic                 item_valid_o,
  output item_t                item_o
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  item_t      in_item;
  logic       push, pop;

  always_comb begin
    in_item.op          = op_e'(s_axis_tuser);
    in_item.entry_index = s_axis_tdata[3:0];
    in_item.kind        = kind_e'(s_axis_tdata[5:4]);
    in_item.size_a      = s_axis_tdata[21:6];
    in_item.size_b      = s_axis_tdata[37:22];
    in_item.ratio       = s_axis_tdata[53:38];
    in_item.cell_col    = s_axis_tdata[63:54];
    in_item.cell_row    = s_axis_tdata[73:64];
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign item_valid_o  = (count_q != 2'd0);
  assign item_o        = fifo_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- design/abg_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module abg_divider import abg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign quo_o  = num_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

endmodule

// ----- design/abg_sqrt.sv -----
// Integer square root, one root bit per cycle.
module abg_sqrt import abg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic [NUM_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[NUM_W-1:NUM_W-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign busy_o = busy_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[NUM_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(ROOT_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

endmodule

// ----- design/abg_back.sv -----
// Back end: shape table, per-entry box sequencer and output register.
module abg_back import abg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  box_valid_o,
  input  logic  box_ready_i,
  output box_t  box_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CENTER, S_FETCH, S_PROD, S_RAD, S_SQRT_W, S_DIV_H, S_SQRT_H,
    S_EDGE_MUL, S_EDGE_SUM, S_EDGE_DIV, S_EDGE_WAIT, S_EMIT
  } state_e;

  localparam int CX_W = 31;
  localparam int DN_W = 22;
  localparam int PM_W = 36;
  localparam int N_W = 38;
  localparam int MAG_W = 37;

  state_e state_q;
  shape_t table_q [TABLE_ENTRIES];
  shape_t ent_q;
  logic [11:0] iw_q, ih_q;
  logic [9:0]  mw_q, mh_q, col_q, row_q;
  logic        clip_q;
  logic [4:0]  cnt_q, k_q;
  logic [1:0]  e_q;
  logic [CX_W-1:0] cx_q, cy_q;
  logic [DN_W-1:0] dx_q, dy_q;
  logic [31:0] prod_q;
  logic [SIZE_W-1:0] w_q, h_q;
  logic        fits_q, hasfit_q;
  logic [PM_W-1:0] pm_q;
  logic [MAG_W-1:0] mag_q;
  logic        neg_q;
  logic signed [COORD_W-1:0] coord_q [4];
  box_t        box_q;
  logic        box_valid_q;

  logic        sq_start, sq_busy, dv_start, dv_busy;
  logic [NUM_W-1:0]  sq_rad, dv_num, quo;
  logic [DEN_W-1:0]  dv_den;
  logic [ROOT_W-1:0] root;
  logic [15:0] r_eff;
  logic [4:0]  cnt_eff;
  logic [DN_W-1:0] den_sel;
  logic [CX_W-1:0] cen_sel;
  logic signed [N_W-1:0] n_val;
  logic signed [COORD_W-1:0] coord_val;
  logic        out_free;
  logic        emit;

  assign r_eff    = (ent_q.r == '0) ? 16'd1 : ent_q.r;
  assign cnt_eff  = (cfg_i.entry_count > 5'(TABLE_ENTRIES)) ? 5'(TABLE_ENTRIES)
                                                            : cfg_i.entry_count;
  assign den_sel  = e_q[0] ? dy_q : dx_q;
  assign cen_sel  = e_q[0] ? cy_q : cx_q;
  assign out_free = !box_valid_q || box_ready_i;
  assign emit     = (state_q == S_EMIT) && out_free;
  assign pop_o    = (state_q == S_IDLE) && item_valid_i;
  assign box_valid_o = box_valid_q;
  assign box_o    = box_q;

  // Center plus or minus half size; the edge order is xmin, ymin, xmax, ymax.
  assign n_val = e_q[1] ? $signed({7'd0, cen_sel}) + $signed({2'd0, pm_q})
                        : $signed({7'd0, cen_sel}) - $signed({2'd0, pm_q});

  always_comb begin
    if (clip_q) begin
      if (neg_q) coord_val = '0;
      else if (quo > NUM_W'(65536)) coord_val = COORD_W'(65536);
      else coord_val = COORD_W'(quo);
    end else if (neg_q) begin
      if (quo > NUM_W'(524288)) coord_val = COORD_W'(20'h80000);
      else coord_val = COORD_W'(-quo);
    end else begin
      if (quo > NUM_W'(524287)) coord_val = COORD_W'(20'h7FFFF);
      else coord_val = COORD_W'(quo);
    end
  end

  always_comb begin
    sq_start = 1'b0;
    sq_rad   = '0;
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    unique case (state_q)
      S_RAD: begin
        sq_start = 1'b1;
        if (ent_q.kind == KIND_SQRT) sq_rad = NUM_W'({prod_q, 8'd0});
        else sq_rad = NUM_W'(48'(prod_q * r_eff) >> 4);
      end
      S_SQRT_W: begin
        if (!sq_busy && ent_q.kind == KIND_RATIO) begin
          dv_start = 1'b1;
          dv_num   = {prod_q, 20'd0};
          dv_den   = DEN_W'(r_eff);
        end
      end
      S_DIV_H: begin
        if (!dv_busy) begin
          sq_start = 1'b1;
          sq_rad   = quo;
        end
      end
      S_EDGE_DIV: begin
        dv_start = 1'b1;
        dv_num   = NUM_W'({mag_q, 8'd0}) + NUM_W'(den_sel);
        dv_den   = {den_sel, 1'b0};
      end
      default: ;
    endcase
  end

  abg_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad), .busy_o(sq_busy), .root_o(root)
  );

  abg_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .busy_o(dv_busy), .quo_o(quo)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.op == OP_LOAD) begin
      table_q[item_i.entry_index[IDX_W-1:0]] <= '{kind: item_i.kind, a: item_i.size_a,
                                                 b: item_i.size_b, r: item_i.ratio};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      box_valid_q <= 1'b0;
      k_q         <= '0;
      e_q         <= '0;
      cnt_q       <= '0;
    end else begin
      if (emit) box_valid_q <= 1'b1;
      else if (box_ready_i) box_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i && item_i.op == OP_CELL && cnt_eff != '0) begin
            iw_q   <= (cfg_i.image_width == '0) ? 12'd1 : cfg_i.image_width;
            ih_q   <= (cfg_i.image_height == '0) ? 12'd1 : cfg_i.image_height;
            mw_q   <= (cfg_i.map_width == '0) ? 10'd1 : cfg_i.map_width;
            mh_q   <= (cfg_i.map_height == '0) ? 10'd1 : cfg_i.map_height;
            clip_q <= cfg_i.clip_enable;
            cnt_q  <= cnt_eff;
            col_q  <= item_i.cell_col;
            row_q  <= item_i.cell_row;
            k_q    <= '0;
            state_q <= S_CENTER;
          end
        end
        S_CENTER: begin
          cx_q <= CX_W'({23'({col_q, 1'b1} * iw_q), 8'd0});
          cy_q <= CX_W'({23'({row_q, 1'b1} * ih_q), 8'd0});
          dx_q <= DN_W'(mw_q * iw_q);
          dy_q <= DN_W'(mh_q * ih_q);
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          ent_q   <= table_q[k_q[IDX_W-1:0]];
          state_q <= S_PROD;
        end
        S_PROD: begin
          fits_q   <= 1'b0;
          hasfit_q <= 1'b0;
          w_q <= SIZE_W'({ent_q.a, 4'd0});
          h_q <= SIZE_W'({ent_q.a, 4'd0});
          e_q <= '0;
          case (ent_q.kind)
            KIND_MIN: state_q <= S_EDGE_MUL;
            KIND_FIXED: begin
              h_q      <= SIZE_W'({ent_q.b, 4'd0});
              hasfit_q <= 1'b1;
              fits_q   <= (ent_q.a <= {iw_q, 4'd0}) && (ent_q.b <= {ih_q, 4'd0});
              state_q  <= S_EDGE_MUL;
            end
            KIND_SQRT: begin
              prod_q  <= ent_q.a * ent_q.b;
              state_q <= S_RAD;
            end
            default: begin
              prod_q  <= ent_q.a * ent_q.a;
              state_q <= S_RAD;
            end
          endcase
        end
        S_RAD: state_q <= S_SQRT_W;
        S_SQRT_W: begin
          if (!sq_busy) begin
            w_q <= root;
            h_q <= root;
            state_q <= (ent_q.kind == KIND_RATIO) ? S_DIV_H : S_EDGE_MUL;
          end
        end
        S_DIV_H: if (!dv_busy) state_q <= S_SQRT_H;
        S_SQRT_H: begin
          if (!sq_busy) begin
            h_q     <= root;
            state_q <= S_EDGE_MUL;
          end
        end
        S_EDGE_MUL: begin
          pm_q <= e_q[0] ? h_q * mh_q : w_q * mw_q;
          state_q <= S_EDGE_SUM;
        end
        S_EDGE_SUM: begin
          neg_q   <= n_val[N_W-1];
          mag_q   <= n_val[N_W-1] ? MAG_W'(-n_val) : MAG_W'(n_val);
          state_q <= S_EDGE_DIV;
        end
        S_EDGE_DIV: state_q <= S_EDGE_WAIT;
        S_EDGE_WAIT: begin
          if (!dv_busy) begin
            coord_q[e_q] <= coord_val;
            e_q <= e_q + 1'b1;
            state_q <= (e_q == 2'd3) ? S_EMIT : S_EDGE_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            box_q <= '{xmin: coord_q[0], ymin: coord_q[1], xmax: coord_q[2],
                       ymax: coord_q[3], fits_image: fits_q, has_fit_flag: hasfit_q,
                       shape_index: k_q[3:0], last_box: (k_q + 1'b1 == cnt_q)};
            k_q <= k_q + 1'b1;
            state_q <= (k_q + 1'b1 == cnt_q) ? S_IDLE : S_FETCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/anchor_box_checker.sv -----
// Monitor, box predictor and scoreboard of the anchor box generator.
module anchor_box_checker import abg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    boxes_pending_o,
  output int                    boxes_seen_o,
  output int                    cells_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  shape_t shapes [TABLE_ENTRIES];
  cfg_t   regs;
  box_t   box_q [$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] box_edge(longint unsigned ctr, longint unsigned sz,
                                                  longint unsigned mapn, longint unsigned img,
                                                  bit upper);
    longint n, v;
    longint unsigned mag, den, q;
    n = upper ? longint'(ctr) + longint'(sz * mapn) : longint'(ctr) - longint'(sz * mapn);
    mag = (n < 0) ? longint'(-n) : n;
    den = mapn * img;
    q = (mag * 256 + den) / (2 * den);
    v = (n < 0) ? -longint'(q) : longint'(q);
    if (regs.clip_enable) begin
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
    end else begin
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
    end
    return v[COORD_W-1:0];
  endfunction

  // Queue every box that one cell produces, in table order.
  task automatic predict_cell(logic [9:0] col, logic [9:0] row);
    longint unsigned iw, ih, mw, mh, cx, cy, a, b, r, w, h;
    int cnt;
    box_t bx;
    iw = (regs.image_width == 0) ? 1 : regs.image_width;
    ih = (regs.image_height == 0) ? 1 : regs.image_height;
    mw = (regs.map_width == 0) ? 1 : regs.map_width;
    mh = (regs.map_height == 0) ? 1 : regs.map_height;
    cnt = (regs.entry_count > 16) ? 16 : regs.entry_count;
    cx = (2 * longint'(col) + 1) * 256 * iw;
    cy = (2 * longint'(row) + 1) * 256 * ih;
    for (int k = 0; k < cnt; k++) begin
      a = shapes[k].a;
      b = shapes[k].b;
      r = (shapes[k].r == 0) ? 1 : shapes[k].r;
      bx = '0;
      case (shapes[k].kind)
        KIND_MIN: begin
          w = a * 16;
          h = w;
        end
        KIND_SQRT: begin
          w = int_sqrt(a * b * 256);
          h = w;
        end
        KIND_RATIO: begin
          w = int_sqrt((a * a * r) >> 4);
          h = int_sqrt((a * a << 20) / r);
        end
        default: begin
          w = a * 16;
          h = b * 16;
          bx.has_fit_flag = 1'b1;
          bx.fits_image = (a <= iw * 16) && (b <= ih * 16);
        end
      endcase
      bx.xmin = box_edge(cx, w, mw, iw, 1'b0);
      bx.ymin = box_edge(cy, h, mh, ih, 1'b0);
      bx.xmax = box_edge(cx, w, mw, iw, 1'b1);
      bx.ymax = box_edge(cy, h, mh, ih, 1'b1);
      bx.shape_index = k[3:0];
      bx.last_box = (k + 1 == cnt);
      box_q.insert(box_q.size(), bx);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] box mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    boxes_seen_o = 0;
    cells_seen_o = 0;
    regs = '{12'd300, 12'd300, 10'd38, 10'd38, 5'd0, 1'b0};
    foreach (shapes[i]) shapes[i] = '0;
  end

  assign boxes_pending_o = box_q.size();

  always @(posedge clk_i) begin
    box_t want;
    if (rst_ni) begin
      // Compare a box transfer against the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        boxes_seen_o++;
        if (box_q.size() == 0) begin
          $display("[%0t] box transfer with nothing predicted", $time);
          fail_count_o++;
        end else begin
          want = box_q.pop_front();
          if (m_axis_tdata[19:0] !== want.xmin)
            report_mismatch("xmin", {12'd0, m_axis_tdata[19:0]}, {12'd0, want.xmin});
          if (m_axis_tdata[39:20] !== want.ymin)
            report_mismatch("ymin", {12'd0, m_axis_tdata[39:20]}, {12'd0, want.ymin});
          if (m_axis_tdata[59:40] !== want.xmax)
            report_mismatch("xmax", {12'd0, m_axis_tdata[59:40]}, {12'd0, want.xmax});
          if (m_axis_tdata[79:60] !== want.ymax)
            report_mismatch("ymax", {12'd0, m_axis_tdata[79:60]}, {12'd0, want.ymax});
          if (m_axis_tdata[83:80] !== want.shape_index)
            report_mismatch("shape_index", {28'd0, m_axis_tdata[83:80]},
                            {28'd0, want.shape_index});
          if (m_axis_tuser[0] !== want.fits_image)
            report_mismatch("fits_image", {31'd0, m_axis_tuser[0]}, {31'd0, want.fits_image});
          if (m_axis_tuser[1] !== want.has_fit_flag)
            report_mismatch("has_fit_flag", {31'd0, m_axis_tuser[1]},
                            {31'd0, want.has_fit_flag});
          if (m_axis_tlast !== want.last_box)
            report_mismatch("last_box", {31'd0, m_axis_tlast}, {31'd0, want.last_box});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD) begin
          shapes[s_axis_tdata[3:0]] = '{kind_e'(s_axis_tdata[5:4]), s_axis_tdata[21:6],
                                        s_axis_tdata[37:22], s_axis_tdata[53:38]};
        end else begin
          cells_seen_o++;
          predict_cell(s_axis_tdata[63:54], s_axis_tdata[73:64]);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  regs.image_width = cfg_data_i[11:0];
          CFG_IMAGE_HEIGHT: regs.image_height = cfg_data_i[11:0];
          CFG_MAP_WIDTH:    regs.map_width = cfg_data_i[9:0];
          CFG_MAP_HEIGHT:   regs.map_height = cfg_data_i[9:0];
          CFG_ENTRY_COUNT:  regs.entry_count = cfg_data_i[4:0];
          CFG_CLIP_ENABLE:  regs.clip_enable = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/anchor_box_generator_tb.sv -----
// Stimulus and verdict for the anchor box generator.
module anchor_box_generator_tb import abg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count, boxes_pending, boxes_seen, cells_seen;

  // Sender and receiver pacing: calm turns idling off, hold_req asks for a long stall.
  bit calm;
  bit hold_req;
  int items_sent;

  anchor_box_generator dut (.*);

  anchor_box_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .boxes_pending_o(boxes_pending),
    .boxes_seen_o(boxes_seen), .cells_seen_o(cells_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #300_000_000;
    $display("timeout waiting for boxes");
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random back-pressure, a long hold on request, none while calm.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (2000) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Offer one item; return with tvalid still high once it has been taken.
  task automatic send_item(op_e op, logic [IN_DATA_W-1:0] data);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_shape(int idx, kind_e kind, int a, int b, int r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[3:0] = 4'(idx);
    d[5:4] = kind;
    d[21:6] = 16'(a);
    d[37:22] = 16'(b);
    d[53:38] = 16'(r);
    d[73:54] = 20'($urandom());  // cell fields are don't-care on a load
    send_item(OP_LOAD, d);
  endtask

  task automatic send_cell(int col, int row);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[53:0] = 54'({$urandom(), $urandom()});  // shape fields are don't-care on a cell
    d[63:54] = 10'(col);
    d[73:64] = 10'(row);
    send_item(OP_CELL, d);
  endtask

  // Drop tvalid, drain every predicted box, then let trailing loads settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (boxes_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 12) return 16;
    if (roll < 17) return $urandom_range(17, 31);
    return $urandom_range(1, 4);
  endfunction

  function automatic int pick_dim(int top);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 1;
    if (roll == 1) return top;
    if (roll == 2) return 0;
    return $urandom_range(1, top);
  endfunction

  initial begin
    int sz;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fill the whole table, corner shapes first and random ones last, before any cell reads it.
    load_shape(0, KIND_MIN, 0, 0, 0);
    load_shape(1, KIND_MIN, 65535, 65535, 65535);
    load_shape(2, KIND_SQRT, 480, 1600, 4096);
    load_shape(3, KIND_SQRT, 65535, 65535, 1);
    load_shape(4, KIND_RATIO, 960, 0, 4096);      // unit ratio gives a square
    load_shape(5, KIND_RATIO, 960, 0, 0);         // zero ratio acts as the smallest code
    load_shape(6, KIND_RATIO, 65535, 0, 65535);
    load_shape(7, KIND_RATIO, 800, 0, 8192);
    load_shape(8, KIND_FIXED, 1600, 2400, 0);     // fits the image
    load_shape(9, KIND_FIXED, 4800, 4801, 0);     // just too tall
    load_shape(10, KIND_FIXED, 65535, 0, 0);
    load_shape(11, KIND_FIXED, 4800, 4800, 0);    // exactly image sized
    for (int i = 12; i < 16; i++)
      load_shape(i, kind_e'(i - 12), $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535));
    send_cell(0, 0);                              // entry count zero: no boxes
    drain();
    write_reg(CFG_ENTRY_COUNT, 16);
    send_cell(0, 0);
    send_cell(37, 37);
    send_cell(1022, 1022);                        // far outside the map, saturates
    drain();
    write_reg(CFG_CLIP_ENABLE, 1);
    write_reg(CFG_ENTRY_COUNT, 31);               // saturates to the table size
    write_reg(CFG_IMAGE_WIDTH, 4095);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    write_reg(CFG_MAP_WIDTH, 1023);
    write_reg(CFG_MAP_HEIGHT, 1);
    send_cell(0, 0);
    send_cell(1022, 0);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 0);                // zero sizes act as one
    write_reg(CFG_MAP_HEIGHT, 0);
    write_reg(CFG_CLIP_ENABLE, 0);
    write_reg(CFG_ENTRY_COUNT, 3);
    send_cell(5, 9);
    drain();

    // Random phases: new settings, then a mix of loads and cells.
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_IMAGE_WIDTH, pick_dim(4095));
      write_reg(CFG_IMAGE_HEIGHT, pick_dim(4095));
      write_reg(CFG_MAP_WIDTH, pick_dim(1023));
      write_reg(CFG_MAP_HEIGHT, pick_dim(1023));
      write_reg(CFG_ENTRY_COUNT, (ph == 2) ? 16 : pick_count());
      write_reg(CFG_CLIP_ENABLE, $urandom_range(0, 1));
      calm = (ph == 4);
      if (ph == 6) begin
        write_reg(CFG_ENTRY_COUNT, 2);
        hold_req = 1'b1;
      end
      for (int n = 0; n < 42; n++) begin
        if ($urandom_range(0, 99) < 30) begin
          sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(16, 8000);
          load_shape($urandom_range(0, 15), kind_e'($urandom_range(0, 3)), sz,
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else begin
          send_cell($urandom_range(0, 1022), $urandom_range(0, 1022));
        end
      end
      drain();
    end
    calm = 1'b0;

    repeat (50) @(posedge clk_i);
    $display("covered %0d input transfers, %0d cells and %0d boxes checked",
             items_sent, cells_seen, boxes_seen);
    $display("settings swept include zero and full-scale sizes, clip on and off, long stall");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
